### design/wrs_pkg.sv
// -----------------------------------------------------------------------------
// wrs_pkg - sliding window regression slope shared definitions
// widths, limits and the job word passed from the front end to the back end
// -----------------------------------------------------------------------------
package wrs_pkg;

   // window and field sizes
   localparam int WINDOW     = 15;
   localparam int SAMPLE_W   = 16;
   localparam int CFG_W      = 4;
   localparam int SLOPE_W    = 21;
   localparam int PTS_W      = 4;
   localparam int MIN_FIT    = 2;
   localparam int FRAC_SHIFT = 4;

   localparam logic [CFG_W-1:0] MIN_POINTS_RST = CFG_W'(5);

   // ring pointer and sample count
   localparam int PTR_W = $clog2(WINDOW);
   localparam int CNT_W = $clog2(WINDOW + 1);

   // sum widths, sized from the largest window sums
   localparam int SX_MAX  = WINDOW * (WINDOW - 1) / 2;
   localparam int SXX_MAX = (WINDOW - 1) * WINDOW * (2 * WINDOW - 1) / 6;
   localparam int SX_W    = $clog2(SX_MAX + 1);
   localparam int SXX_W   = $clog2(SXX_MAX + 1);
   localparam int SY_W    = SAMPLE_W + CNT_W;
   localparam int SXY_W   = SAMPLE_W + SX_W;

   // cross products and quotient
   localparam int PA_W   = CNT_W + SXY_W;
   localparam int PB_W   = SX_W + SY_W;
   localparam int PROD_W = (PA_W > PB_W) ? PA_W : PB_W;
   localparam int PD_W   = 2 * SX_W;
   localparam int DEN_W  = CNT_W + SXX_W;
   localparam int MAG_W  = PROD_W + FRAC_SHIFT;
   localparam int DCNT_W = $clog2(MAG_W + 1);
   localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

   // saturation limits as magnitudes
   localparam logic [MAG_W-1:0] SAT_POS_MAG = MAG_W'((64'd1 << (SLOPE_W - 1)) - 64'd1);
   localparam logic [MAG_W-1:0] SAT_NEG_MAG = MAG_W'(64'd1 << (SLOPE_W - 1));
   localparam logic [SLOPE_W-1:0] SLOPE_POS_LIM = SLOPE_W'(SAT_POS_MAG);
   localparam logic [SLOPE_W-1:0] SLOPE_NEG_LIM = SLOPE_W'(SAT_NEG_MAG);

   // job queue
   localparam int QDEPTH = 2;
   localparam int QPTR_W = 1;
   localparam int QCNT_W = 2;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic [PTR_W-1:0]    wr_pos;
      logic [PTR_W-1:0]    start;
      logic [CNT_W-1:0]    n;
      logic                fit;
   } job_type;

endpackage

### design/wrs_front.sv
// -----------------------------------------------------------------------------
// wrs_front - input side of the slope unit
// takes sample words, tracks ring position and fill, decides whether a fit
// is due and pushes a job word into the queue
// -----------------------------------------------------------------------------
module wrs_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [wrs_pkg::SAMPLE_W-1:0]     req_sample,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [wrs_pkg::CFG_W-1:0]        csr_min_points,
   output logic                             q_push,
   output wrs_pkg::job_type                 q_job,
   input  logic                             q_full
);

   logic [wrs_pkg::PTR_W-1:0] wp_ff, wp_in;
   logic                      full_ff, full_in;
   logic [wrs_pkg::CFG_W-1:0] min_points_ff, min_points_in;

   logic                      wrap;
   logic [wrs_pkg::PTR_W-1:0] wp_next;
   logic                      full_next;
   logic [wrs_pkg::CNT_W-1:0] n_next;
   logic [wrs_pkg::CFG_W-1:0] need;

   assign req_ready = !q_full;
   assign csr_ready = 1'b1;
   assign q_push    = req_valid && req_ready;

   always_comb begin
      wrap      = (wp_ff == wrs_pkg::PTR_W'(wrs_pkg::WINDOW - 1));
      wp_next   = wrap ? '0 : wp_ff + 1'b1;
      full_next = full_ff || wrap;
      n_next    = full_next ? wrs_pkg::CNT_W'(wrs_pkg::WINDOW) : wrs_pkg::CNT_W'(wp_next);
      need      = (min_points_ff < wrs_pkg::CFG_W'(wrs_pkg::MIN_FIT)) ?
                  wrs_pkg::CFG_W'(wrs_pkg::MIN_FIT) : min_points_ff;

      q_job.sample = req_sample;
      q_job.wr_pos = wp_ff;
      // oldest stored sample: slot zero until the ring wraps, then the next slot
      q_job.start  = full_next ? wp_next : '0;
      q_job.n      = n_next;
      q_job.fit    = wrs_pkg::CMP_W'(n_next) >= wrs_pkg::CMP_W'(need);

      wp_in         = q_push ? wp_next : wp_ff;
      full_in       = q_push ? full_next : full_ff;
      min_points_in = (csr_valid && csr_ready) ? csr_min_points : min_points_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff         <= '0;
         full_ff       <= 1'b0;
         min_points_ff <= wrs_pkg::MIN_POINTS_RST;
      end else begin
         wp_ff         <= wp_in;
         full_ff       <= full_in;
         min_points_ff <= min_points_in;
      end
   end

   a_wp_range: assert property (@(posedge clock) disable iff (reset)
      wp_ff < wrs_pkg::PTR_W'(wrs_pkg::WINDOW))
      else $error("ring write position out of range");

   a_fit_count: assert property (@(posedge clock) disable iff (reset)
      (q_push && q_job.fit) |-> (q_job.n >= wrs_pkg::CNT_W'(wrs_pkg::MIN_FIT)))
      else $error("fit requested with fewer than two samples");

   a_start_zero: assert property (@(posedge clock) disable iff (reset)
      (q_push && !full_ff && !wrap) |-> (q_job.start == '0))
      else $error("fit start not at slot zero before the ring wrapped");

endmodule

### design/wrs_queue.sv
// -----------------------------------------------------------------------------
// wrs_queue - two-entry job queue
// decouples the input side from the fit sequencer
// -----------------------------------------------------------------------------
module wrs_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  wrs_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output wrs_pkg::job_type pop_job
);

   wrs_pkg::job_type           entry_ff [wrs_pkg::QDEPTH];
   logic [wrs_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [wrs_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [wrs_pkg::QCNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == wrs_pkg::QCNT_W'(wrs_pkg::QDEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_job   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("job queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("job queue underflow");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= wrs_pkg::QCNT_W'(wrs_pkg::QDEPTH))
      else $error("job queue count out of range");

endmodule

### design/wrs_back.sv
// -----------------------------------------------------------------------------
// wrs_back - fit sequencer
// writes the sample into the ring; for a fit, walks the window accumulating
// the sums, forms numerator and denominator, divides one bit a cycle and saturates
// -----------------------------------------------------------------------------
module wrs_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_valid,
   input  wrs_pkg::job_type                   q_job,
   output logic                               q_pop,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [wrs_pkg::SLOPE_W-1:0] rsp_slope,
   output logic                               rsp_slope_ready,
   output logic [wrs_pkg::PTS_W-1:0]          rsp_points_used
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_WALK = 6'b000010,
      ST_MUL  = 6'b000100,
      ST_DIFF = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_DONE = 6'b100000
   } back_state_type;

   back_state_type state_ff, state_in;

   // ring memory
   logic [wrs_pkg::SAMPLE_W-1:0] ring_mem [wrs_pkg::WINDOW];
   logic                         wr_en;
   logic                         rd_en;
   logic [wrs_pkg::SAMPLE_W-1:0] rd_data_ff;

   // job and walk
   logic [wrs_pkg::CNT_W-1:0] n_ff, n_in;
   logic                      fit_ff, fit_in;
   logic [wrs_pkg::PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [wrs_pkg::CNT_W-1:0] iss_ff, iss_in;
   logic                      pend_ff, pend_in;
   logic [wrs_pkg::PTR_W-1:0] pend_x_ff, pend_x_in;

   // sums
   logic [wrs_pkg::SX_W-1:0]  sx_ff, sx_in;
   logic [wrs_pkg::SXX_W-1:0] sxx_ff, sxx_in;
   logic [wrs_pkg::SY_W-1:0]  sy_ff, sy_in;
   logic [wrs_pkg::SXY_W-1:0] sxy_ff, sxy_in;

   // products
   logic [wrs_pkg::PA_W-1:0]  pa_ff, pa_in;
   logic [wrs_pkg::PB_W-1:0]  pb_ff, pb_in;
   logic [wrs_pkg::DEN_W-1:0] pc_ff, pc_in;
   logic [wrs_pkg::PD_W-1:0]  pd_ff, pd_in;

   // divider
   logic                       neg_ff, neg_in;
   logic [wrs_pkg::DEN_W-1:0]  den_ff, den_in;
   logic [wrs_pkg::DEN_W:0]    rem_ff, rem_in;
   logic [wrs_pkg::MAG_W-1:0]  quo_ff, quo_in;
   logic [wrs_pkg::DCNT_W-1:0] dcnt_ff, dcnt_in;

   // result register
   logic                               out_valid_ff, out_valid_in;
   logic signed [wrs_pkg::SLOPE_W-1:0] out_slope_ff, out_slope_in;
   logic                               out_rdy_ff, out_rdy_in;
   logic [wrs_pkg::PTS_W-1:0]          out_pts_ff, out_pts_in;

   // helpers
   logic [wrs_pkg::PROD_W:0]   pa_x, pb_x, diff;
   logic [wrs_pkg::DEN_W:0]    rem_sh;
   logic                       rem_ge;
   logic [wrs_pkg::SLOPE_W-1:0] slope_sat;
   logic                       out_free;

   assign rsp_valid       = out_valid_ff;
   assign rsp_slope       = out_slope_ff;
   assign rsp_slope_ready = out_rdy_ff;
   assign rsp_points_used = out_pts_ff;

   assign out_free = !out_valid_ff || rsp_ready;
   assign q_pop    = (state_ff == ST_IDLE) && q_valid;
   assign wr_en    = q_pop;
   assign rd_en    = (state_ff == ST_WALK) && (iss_ff != n_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[q_job.wr_pos] <= q_job.sample;
      end
      if (rd_en) begin
         rd_data_ff <= ring_mem[rd_ptr_ff];
      end
   end

   always_comb begin
      pa_x   = (wrs_pkg::PROD_W + 1)'(pa_ff);
      pb_x   = (wrs_pkg::PROD_W + 1)'(pb_ff);
      diff   = (pb_x > pa_x) ? pb_x - pa_x : pa_x - pb_x;
      rem_sh = {rem_ff[wrs_pkg::DEN_W-1:0], quo_ff[wrs_pkg::MAG_W-1]};
      rem_ge = rem_sh >= {1'b0, den_ff};

      // truncation toward zero: clamp the magnitude, and negate it for a negative slope
      if (neg_ff) begin
         slope_sat = (quo_ff > wrs_pkg::SAT_NEG_MAG) ? wrs_pkg::SLOPE_NEG_LIM :
                     wrs_pkg::SLOPE_W'(-wrs_pkg::SLOPE_W'(quo_ff));
      end else begin
         slope_sat = (quo_ff > wrs_pkg::SAT_POS_MAG) ? wrs_pkg::SLOPE_POS_LIM :
                     wrs_pkg::SLOPE_W'(quo_ff);
      end
   end

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      fit_in       = fit_ff;
      rd_ptr_in    = rd_ptr_ff;
      iss_in       = iss_ff;
      pend_in      = 1'b0;
      pend_x_in    = pend_x_ff;
      sx_in        = sx_ff;
      sxx_in       = sxx_ff;
      sy_in        = sy_ff;
      sxy_in       = sxy_ff;
      pa_in        = pa_ff;
      pb_in        = pb_ff;
      pc_in        = pc_ff;
      pd_in        = pd_ff;
      neg_in       = neg_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dcnt_in      = dcnt_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_slope_in = out_slope_ff;
      out_rdy_in   = out_rdy_ff;
      out_pts_in   = out_pts_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               n_in      = q_job.n;
               fit_in    = q_job.fit;
               rd_ptr_in = q_job.start;
               iss_in    = '0;
               sx_in     = '0;
               sxx_in    = '0;
               sy_in     = '0;
               sxy_in    = '0;
               neg_in    = 1'b0;
               quo_in    = '0;
               state_in  = q_job.fit ? ST_WALK : ST_DONE;
            end
         end
         ST_WALK: begin
            if (rd_en) begin
               pend_in   = 1'b1;
               pend_x_in = wrs_pkg::PTR_W'(iss_ff);
               iss_in    = iss_ff + 1'b1;
               rd_ptr_in = (rd_ptr_ff == wrs_pkg::PTR_W'(wrs_pkg::WINDOW - 1)) ?
                           '0 : rd_ptr_ff + 1'b1;
            end
            if (pend_ff) begin
               sx_in  = sx_ff + wrs_pkg::SX_W'(pend_x_ff);
               sxx_in = sxx_ff + wrs_pkg::SXX_W'(pend_x_ff) * wrs_pkg::SXX_W'(pend_x_ff);
               sy_in  = sy_ff + wrs_pkg::SY_W'(rd_data_ff);
               sxy_in = sxy_ff + wrs_pkg::SXY_W'(pend_x_ff) * wrs_pkg::SXY_W'(rd_data_ff);
            end
            if (!rd_en && !pend_ff) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            pa_in    = wrs_pkg::PA_W'(n_ff) * wrs_pkg::PA_W'(sxy_ff);
            pb_in    = wrs_pkg::PB_W'(sx_ff) * wrs_pkg::PB_W'(sy_ff);
            pc_in    = wrs_pkg::DEN_W'(n_ff) * wrs_pkg::DEN_W'(sxx_ff);
            pd_in    = wrs_pkg::PD_W'(sx_ff) * wrs_pkg::PD_W'(sx_ff);
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            neg_in   = pb_x > pa_x;
            quo_in   = {diff[wrs_pkg::PROD_W-1:0], wrs_pkg::FRAC_SHIFT'(0)};
            den_in   = pc_ff - wrs_pkg::DEN_W'(pd_ff);
            rem_in   = '0;
            dcnt_in  = wrs_pkg::DCNT_W'(wrs_pkg::MAG_W);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = rem_ge ? rem_sh - {1'b0, den_ff} : rem_sh;
            quo_in  = {quo_ff[wrs_pkg::MAG_W-2:0], rem_ge};
            dcnt_in = dcnt_ff - 1'b1;
            if (dcnt_ff == wrs_pkg::DCNT_W'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_slope_in = fit_ff ? slope_sat : '0;
               out_rdy_in   = fit_ff;
               out_pts_in   = wrs_pkg::PTS_W'(n_ff);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      fit_ff       <= fit_in;
      rd_ptr_ff    <= rd_ptr_in;
      iss_ff       <= iss_in;
      pend_x_ff    <= pend_x_in;
      sx_ff        <= sx_in;
      sxx_ff       <= sxx_in;
      sy_ff        <= sy_in;
      sxy_ff       <= sxy_in;
      pa_ff        <= pa_in;
      pb_ff        <= pb_in;
      pc_ff        <= pc_in;
      pd_ff        <= pd_in;
      neg_ff       <= neg_in;
      den_ff       <= den_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      dcnt_ff      <= dcnt_in;
      out_slope_ff <= out_slope_in;
      out_rdy_ff   <= out_rdy_in;
      out_pts_ff   <= out_pts_in;
   end

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == ST_IDLE))
      else $error("job taken while sequencer busy");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (iss_ff <= n_ff))
      else $error("window walk ran past the sample count");

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (den_ff != '0))
      else $error("zero denominator in slope division");

   a_slope_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_rdy_ff) |-> (out_slope_ff == '0))
      else $error("nonzero slope without a fit");

endmodule

### design/window_regression_slope_unit.sv
// -----------------------------------------------------------------------------
// window_regression_slope_unit - sliding window least-squares slope
// keeps the last 15 samples and returns the fitted slope for every sample word
// -----------------------------------------------------------------------------
// path: a fit over n stored samples goes through the queue pop, the ring walk,
//   the products and their difference, the 31-step divider and the result load
// pacing: the sequencer finishes one job before it pops the next, paced by the
//   one-bit-a-cycle divider and the one-read-a-cycle ring walk and held while the
//   result sits unclaimed; words without a fit skip the walk and the divider
// reset: synchronous, clears ring position, fill flag, queue and result valid;
//   min_points returns to 5; ring contents are not cleared and never read stale
// -----------------------------------------------------------------------------
module window_regression_slope_unit (
   input  logic                               clock,
   input  logic                               reset,

   // sample word in
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [wrs_pkg::SAMPLE_W-1:0]       req_sample,

   // slope word out
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [wrs_pkg::SLOPE_W-1:0] rsp_slope,
   output logic                               rsp_slope_ready,
   output logic [wrs_pkg::PTS_W-1:0]          rsp_points_used,

   // min_points register write
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [wrs_pkg::CFG_W-1:0]          csr_min_points
);

   // front end to queue
   logic             q_push;
   wrs_pkg::job_type q_push_job;
   logic             q_full;

   // queue to fit sequencer
   logic             q_pop;
   logic             q_pop_valid;
   wrs_pkg::job_type q_pop_job;

   // front end: tracks where the next sample lands in the ring and how many
   // samples are held, and flags whether this word gets a fit at all
   wrs_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_min_points (csr_min_points),
      .q_push         (q_push),
      .q_job          (q_push_job),
      .q_full         (q_full)
   );

   // short job queue so the input side keeps taking words while the
   // sequencer divides or the result sits unclaimed
   wrs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (q_push_job),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_pop_valid),
      .pop_job   (q_pop_job)
   );

   // fit sequencer: owns the sample ring, so ring writes and the window walk
   // happen strictly in job order and a later sample never clobbers a window
   // that is still being read
   wrs_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_pop_valid),
      .q_job           (q_pop_job),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_slope       (rsp_slope),
      .rsp_slope_ready (rsp_slope_ready),
      .rsp_points_used (rsp_points_used)
   );

endmodule

### tb/slope_fit_checker.sv
// -----------------------------------------------------------------------------
// slope_fit_checker - window slope prediction and result compare
// watches sample, slope and min_points channels, keeps its own copy of the
// sample ring and checks each slope word against the oldest expected word
// -----------------------------------------------------------------------------
module slope_fit_checker
   import wrs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic [SAMPLE_W-1:0]       req_sample,

   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic signed [SLOPE_W-1:0] rsp_slope,
   input  logic                      rsp_slope_ready,
   input  logic [PTS_W-1:0]          rsp_points_used,

   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CFG_W-1:0]          csr_min_points,

   output int                        fail_count,
   output int                        words_due
);

   typedef struct packed {
      logic signed [SLOPE_W-1:0] slope;
      logic                      slope_ready;
      logic [PTS_W-1:0]          points_used;
   } slope_word_t;

   localparam longint SLOPE_HI = (longint'(1) << (SLOPE_W - 1)) - 1;
   localparam longint SLOPE_LO = -(longint'(1) << (SLOPE_W - 1));

   logic [SAMPLE_W-1:0] ring_copy [WINDOW];
   int                  wr_slot;
   bit                  wrapped;
   int                  min_pts;
   int                  errs = 0;
   slope_word_t         slopes_due [$];

   // store one sample and, when enough points are held, fit a line over the stored window
   function automatic slope_word_t fold_in_sample(input logic [SAMPLE_W-1:0] s);
      int          n;
      int          need;
      int          first;
      longint      sx;
      longint      sy;
      longint      sxy;
      longint      sxx;
      longint      y;
      longint      num;
      longint      den;
      longint      q;
      slope_word_t w;
      ring_copy[wr_slot] = s;
      wr_slot = (wr_slot + 1) % WINDOW;
      if (wr_slot == 0) wrapped = 1'b1;
      n = wrapped ? WINDOW : wr_slot;
      // a single point has no slope
      need = (min_pts < MIN_FIT) ? MIN_FIT : min_pts;
      w.slope = '0;
      w.slope_ready = 1'b0;
      w.points_used = PTS_W'(n);
      if (n >= need) begin
         sx = 0;
         sy = 0;
         sxy = 0;
         sxx = 0;
         first = (wr_slot + WINDOW - n) % WINDOW;
         for (int k = 0; k < n; k++) begin
            y = longint'(ring_copy[(first + k) % WINDOW]);
            sx += k;
            sy += y;
            sxy += k * y;
            sxx += k * k;
         end
         den = n * sxx - sx * sx;
         // Q12.4 samples, Q13.8 slope
         num = (n * sxy - sx * sy) <<< FRAC_SHIFT;
         q = (den <= 0) ? 0 : num / den;
         if (q > SLOPE_HI) q = SLOPE_HI;
         if (q < SLOPE_LO) q = SLOPE_LO;
         w.slope = SLOPE_W'(q);
         w.slope_ready = 1'b1;
      end
      return w;
   endfunction

   always @(posedge clock) begin
      slope_word_t want;
      if (reset) begin
         wr_slot = 0;
         wrapped = 1'b0;
         min_pts = MIN_POINTS_RST;
         slopes_due.delete();
      end else begin
         if (csr_valid && csr_ready) min_pts = csr_min_points;
         if (req_valid && req_ready) slopes_due.push_back(fold_in_sample(req_sample));
         if (rsp_valid && rsp_ready) begin
            if (slopes_due.size() == 0) begin
               $error("slope word with none expected: slope %0d", rsp_slope);
               errs++;
            end else begin
               want = slopes_due.pop_front();
               if (rsp_slope !== want.slope) begin
                  $error("slope: expected %0d, got %0d", $signed(want.slope), rsp_slope);
                  errs++;
               end
               if (rsp_slope_ready !== want.slope_ready) begin
                  $error("slope_ready: expected %0d, got %0d", want.slope_ready,
                         rsp_slope_ready);
                  errs++;
               end
               if (rsp_points_used !== want.points_used) begin
                  $error("points_used: expected %0d, got %0d", want.points_used,
                         rsp_points_used);
                  errs++;
               end
            end
         end
      end
      fail_count <= errs;
      words_due <= slopes_due.size();
   end

endmodule

### tb/testbench.sv
// -----------------------------------------------------------------------------
// testbench - window regression slope unit
// drives sample words and min_points writes through several traffic phases;
// a separate checker predicts every slope word and counts mismatches
// -----------------------------------------------------------------------------
module testbench;
   import wrs_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int PHASE_ITEMS  = 300;
   localparam int HOLD_CYCLES  = 400;
   // covers the worst fit latency, with some margin
   localparam int DRAIN_CYCLES = 64;

   logic                      clock;
   logic                      reset          = 1'b1;

   logic                      req_valid      = 1'b0;
   logic                      req_ready;
   logic [SAMPLE_W-1:0]       req_sample     = '0;

   logic                      rsp_valid;
   logic                      rsp_ready      = 1'b0;
   logic signed [SLOPE_W-1:0] rsp_slope;
   logic                      rsp_slope_ready;
   logic [PTS_W-1:0]          rsp_points_used;

   logic                      csr_valid      = 1'b0;
   logic                      csr_ready;
   logic [CFG_W-1:0]          csr_min_points = '0;

   int                        fail_count;
   int                        words_due;

   int                        send_idle_pct  = 0;
   int                        recv_stall_pct = 0;
   logic                      hold_rsp       = 1'b0;
   bit                        pressure_go    = 1'b0;
   int                        cycle_count    = 0;
   logic [SAMPLE_W-1:0]       trend_level    = 16'h4000;

   // opening words: a steep fall over the first two points, zeros and full
   // scale, single bits and alternating patterns, and enough words to wrap
   // the ring and keep sliding past the wrap
   logic [SAMPLE_W-1:0] directed_samples [20] = '{
      16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0001,
      16'h8000, 16'hAAAA, 16'h5555, 16'hFFFF, 16'hFFFF,
      16'h0000, 16'h0000, 16'h0100, 16'h1000, 16'h000F,
      16'hFFF0, 16'h3039, 16'hD431, 16'h0064, 16'h00C8
   };

   window_regression_slope_unit u_top (.*);

   slope_fit_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit, counted from time zero
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // result side: random stalls, or a forced hold-off while hold_rsp is up
   always @(posedge clock)
      rsp_ready <= !hold_rsp && ($urandom_range(0, 99) >= recv_stall_pct);

   // long receiver hold-off, counted here so the sender keeps offering words
   // and the block backs up into its input
   initial begin
      wait (pressure_go);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // random sample: full range, a wandering trend, rails, or small values
   function automatic logic [SAMPLE_W-1:0] next_sample();
      case ($urandom_range(0, 3))
         0: return SAMPLE_W'($urandom);
         1: begin
            trend_level = trend_level + SAMPLE_W'($urandom_range(0, 512)) - 16'd256;
            return trend_level;
         end
         2: return $urandom_range(0, 1) ? '1 : '0;
         default: return SAMPLE_W'($urandom_range(0, 255));
      endcase
   endfunction

   // offer one sample word, with random idle cycles ahead of it
   task automatic offer_sample(input logic [SAMPLE_W-1:0] s);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_sample <= SAMPLE_W'($urandom);
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_min_points(input logic [CFG_W-1:0] v);
      csr_valid <= 1'b1;
      csr_min_points <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // stop offering and wait for every expected slope word to come back
   task automatic drain_slopes();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_due != 0) @(posedge clock);
   endtask

   task automatic run_phase(input logic [CFG_W-1:0] min_pts, input int idle_pct,
                            input int stall_pct);
      drain_slopes();
      write_min_points(min_pts);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (PHASE_ITEMS) offer_sample(next_sample());
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // threshold below two right after reset: the first word holds one
      // point and must come back not ready, the second is the first fit
      write_min_points(CFG_W'(1));
      foreach (directed_samples[i]) offer_sample(directed_samples[i]);

      // top threshold, only a full ring fits; no idling on either side
      run_phase(CFG_W'(15), 0, 0);
      // zero threshold, sender mostly idle
      run_phase(CFG_W'(0), 80, 0);
      // lowest real threshold, receiver mostly stalled
      run_phase(CFG_W'(2), 0, 80);
      // mid threshold, both sides idling now and then
      run_phase(CFG_W'(7), 21, 21);

      // last phase: receiver held off for a long stretch while words keep coming
      drain_slopes();
      write_min_points(CFG_W'($urandom_range(3, 14)));
      send_idle_pct = 0;
      recv_stall_pct = 0;
      pressure_go = 1'b1;
      repeat (PHASE_ITEMS) offer_sample(next_sample());

      drain_slopes();
      // catch any stray word arriving late
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### sim.f
design/wrs_pkg.sv
design/wrs_front.sv
design/wrs_queue.sv
design/wrs_back.sv
design/window_regression_slope_unit.sv
tb/slope_fit_checker.sv
tb/testbench.sv
